### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/sdi_pkg.sv
// ----------------------------------------------------------------------------
// sdi_pkg
// types and constants shared by the sd card init sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdi_pkg;

    // request function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DONE  = 1'b1;

    // configuration register indexes
    localparam int   CFG_IDX_W           = 1;
    localparam logic CFG_RESET_REPEATS   = 1'b0;
    localparam logic CFG_READY_TRY_LIMIT = 1'b1;
    localparam int   CFG_DATA_W          = 16;

    // configuration reset values
    localparam logic [3:0]  RESET_REPEATS_DEF   = 4'd5;
    localparam logic [15:0] READY_TRY_LIMIT_DEF = 16'd10000;

    // sd command numbers
    localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
    localparam logic [5:0] CMD_ALL_SEND_ID = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA    = 6'd3;
    localparam logic [5:0] CMD_SELECT      = 6'd7;
    localparam logic [5:0] CMD_SEND_IF     = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD    = 6'd9;
    localparam logic [5:0] CMD_SD_OP_COND  = 6'd41;
    localparam logic [5:0] CMD_APP         = 6'd55;

    // response kinds
    localparam logic [1:0] RK_NONE  = 2'd0;
    localparam logic [1:0] RK_SHORT = 2'd1;
    localparam logic [1:0] RK_NOCRC = 2'd2;
    localparam logic [1:0] RK_LONG  = 2'd3;

    // command arguments and response masks
    localparam logic [31:0] CMD8_ARG     = 32'h0000_01AA;
    localparam logic [7:0]  CMD8_ECHO    = 8'hAA;
    localparam logic [31:0] OCR_ARG_BASE = 32'h8010_0000;
    localparam logic [31:0] OCR_HCS      = 32'h4000_0000;

    localparam int SECT_W = 33;

    typedef struct packed {
        logic        func;
        logic        timed_out;
        logic        crc_failed;
        logic [31:0] resp_word0;
        logic [31:0] resp_word1;
        logic [31:0] resp_word2;
    } t_step;

    typedef struct packed {
        logic              hc;
        logic [SECT_W-1:0] sectors;
    } t_csd_info;

    typedef struct packed {
        logic              issue_cmd;
        logic [5:0]        cmd_index;
        logic [31:0]       cmd_arg;
        logic [1:0]        resp_kind;
        logic              init_done;
        logic              init_ok;
        logic              card_v2;
        logic              card_hc;
        logic [15:0]       card_rca;
        logic [SECT_W-1:0] sector_count;
        logic              clock_divider;
    } t_result;

endpackage

### rtl/sdi_csd_decode.sv
// ----------------------------------------------------------------------------
// sdi_csd_decode
// capacity decode of a csd register, v1 and v2 layouts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdi_csd_decode
    import sdi_pkg::*;
(
    input  logic [31:0] i_word0,
    input  logic [31:0] i_word1,
    input  logic [31:0] i_word2,
    output t_csd_info   o_csd
);

    logic [3:0]        w_rbl;
    logic [11:0]       w_csize_v1;
    logic [12:0]       w_csize_p1_v1;
    logic [2:0]        w_cmult;
    logic [2:0]        w_bsh;
    logic [3:0]        w_shift;
    logic [21:0]       w_csize_v2;
    logic [22:0]       w_csize_p1_v2;
    logic [SECT_W-1:0] w_sect_v1;
    logic [SECT_W-1:0] w_sect_v2;
    logic              w_hc;

    // v1 layout: (c_size + 1) << (c_size_mult + 2 + read_bl_len - 9)
    assign w_rbl         = i_word1[19:16];
    assign w_csize_v1    = {i_word1[9:0], i_word2[31:30]};
    assign w_csize_p1_v1 = {1'b0, w_csize_v1} + 13'd1;
    assign w_cmult       = {i_word2[17:16], i_word2[15]};
    // block length under 512 bytes adds no shift
    assign w_bsh         = (w_rbl >= 4'd9) ? 3'(w_rbl - 4'd9) : 3'd0;
    assign w_shift       = {1'b0, w_cmult} + 4'd2 + {1'b0, w_bsh};
    assign w_sect_v1     = {20'd0, w_csize_p1_v1} << w_shift;

    // v2 layout: (c_size + 1) * 1024
    assign w_csize_v2    = {i_word1[5:0], i_word2[31:16]};
    assign w_csize_p1_v2 = {1'b0, w_csize_v2} + 23'd1;
    assign w_sect_v2     = {w_csize_p1_v2, 10'd0};

    // any nonzero structure code takes the v2 layout
    assign w_hc = (i_word0[31:30] != 2'b00);

    assign o_csd.hc      = w_hc;
    assign o_csd.sectors = w_hc ? w_sect_v2 : w_sect_v1;

endmodule

### rtl/sdi_ctrl.sv
// ----------------------------------------------------------------------------
// sdi_ctrl
// bring-up phase machine and recorded card facts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdi_ctrl
    import sdi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  t_step       i_step,
    input  logic [3:0]  i_reset_repeats,
    input  logic [15:0] i_ready_try_limit,
    input  t_csd_info   i_csd,
    output t_result     o_result
);

`include "assert_macros.svh"

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CMD0,
        PH_CMD8,
        PH_CMD55,
        PH_ACMD41,
        PH_CMD2,
        PH_CMD3,
        PH_CMD9,
        PH_CMD7,
        PH_OK,
        PH_FAIL
    } t_phase;

    t_phase            r_phase,     n_phase;
    logic [15:0]       r_try_count, n_try_count;
    logic              r_v2,        n_v2;
    logic              r_ocr_hc,    n_ocr_hc;
    logic              r_csd_hc,    n_csd_hc;
    logic [15:0]       r_rca,       n_rca;
    logic [SECT_W-1:0] r_sectors,   n_sectors;

    logic        w_issue;
    logic [5:0]  w_idx;
    logic [31:0] w_arg;
    logic [1:0]  w_kind;
    logic        w_bad;
    logic [31:0] w_r0;
    logic [15:0] w_try_inc;

    assign w_bad     = i_step.timed_out | i_step.crc_failed;
    assign w_r0      = i_step.resp_word0;
    assign w_try_inc = r_try_count + 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_try_count = r_try_count;
        n_v2        = r_v2;
        n_ocr_hc    = r_ocr_hc;
        n_csd_hc    = r_csd_hc;
        n_rca       = r_rca;
        n_sectors   = r_sectors;
        w_issue     = 1'b0;
        w_idx       = CMD_GO_IDLE;
        w_arg       = 32'd0;
        w_kind      = RK_NONE;
        if (i_step.func == FUNC_START) begin
            n_v2        = 1'b0;
            n_ocr_hc    = 1'b0;
            n_csd_hc    = 1'b0;
            n_rca       = 16'd0;
            n_sectors   = '0;
            n_try_count = 16'd1;
            n_phase     = PH_CMD0;
            w_issue     = 1'b1;
        end else begin
            unique case (r_phase)
                PH_CMD0: begin
                    if (r_try_count < {12'd0, i_reset_repeats}) begin
                        n_try_count = w_try_inc;
                        w_issue     = 1'b1;
                    end else if (i_step.timed_out) begin
                        n_phase = PH_FAIL;
                    end else begin
                        n_phase = PH_CMD8;
                        w_issue = 1'b1;
                        w_idx   = CMD_SEND_IF;
                        w_arg   = CMD8_ARG;
                        w_kind  = RK_SHORT;
                    end
                end
                PH_CMD8: begin
                    n_v2 = !w_bad && (w_r0[7:0] == CMD8_ECHO) && (w_r0[14:9] == 6'd0);
                    n_try_count = 16'd0;
                    n_phase     = PH_CMD55;
                    w_issue     = 1'b1;
                    w_idx       = CMD_APP;
                    w_kind      = RK_SHORT;
                end
                PH_CMD55: begin
                    n_phase = PH_ACMD41;
                    w_issue = 1'b1;
                    w_idx   = CMD_SD_OP_COND;
                    w_arg   = OCR_ARG_BASE | (r_v2 ? OCR_HCS : 32'd0);
                    w_kind  = RK_NOCRC;
                end
                PH_ACMD41: begin
                    n_try_count = w_try_inc;
                    w_issue     = 1'b1;
                    if ((!i_step.timed_out && w_r0[31]) ||
                        (w_try_inc >= i_ready_try_limit)) begin
                        n_ocr_hc = r_v2 && w_r0[30];
                        n_phase  = PH_CMD2;
                        w_idx    = CMD_ALL_SEND_ID;
                        w_kind   = RK_LONG;
                    end else begin
                        n_phase = PH_CMD55;
                        w_idx   = CMD_APP;
                        w_kind  = RK_SHORT;
                    end
                end
                PH_CMD2: begin
                    if (w_bad) begin
                        n_phase = PH_FAIL;
                    end else begin
                        n_phase = PH_CMD3;
                        w_issue = 1'b1;
                        w_idx   = CMD_SEND_RCA;
                        w_kind  = RK_SHORT;
                    end
                end
                PH_CMD3: begin
                    if (w_bad) begin
                        n_phase = PH_FAIL;
                    end else begin
                        n_rca   = w_r0[31:16];
                        n_phase = PH_CMD9;
                        w_issue = 1'b1;
                        w_idx   = CMD_SEND_CSD;
                        w_arg   = {w_r0[31:16], 16'd0};
                        w_kind  = RK_LONG;
                    end
                end
                PH_CMD9: begin
                    if (w_bad) begin
                        n_phase = PH_FAIL;
                    end else begin
                        n_csd_hc  = i_csd.hc;
                        n_sectors = i_csd.sectors;
                        n_phase   = PH_CMD7;
                        w_issue   = 1'b1;
                        w_idx     = CMD_SELECT;
                        w_arg     = {r_rca, 16'd0};
                        w_kind    = RK_SHORT;
                    end
                end
                PH_CMD7: begin
                    n_phase = w_bad ? PH_FAIL : PH_OK;
                end
                PH_IDLE, PH_OK, PH_FAIL: begin
                    // finished requests are dropped here
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_try_count <= 16'd0;
            r_v2        <= 1'b0;
            r_ocr_hc    <= 1'b0;
            r_csd_hc    <= 1'b0;
            r_rca       <= 16'd0;
            r_sectors   <= '0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_try_count <= n_try_count;
            r_v2        <= n_v2;
            r_ocr_hc    <= n_ocr_hc;
            r_csd_hc    <= n_csd_hc;
            r_rca       <= n_rca;
            r_sectors   <= n_sectors;
        end
    end

    assign o_result.issue_cmd     = w_issue;
    assign o_result.cmd_index     = w_idx;
    assign o_result.cmd_arg       = w_arg;
    assign o_result.resp_kind     = w_kind;
    assign o_result.init_done     = (n_phase == PH_OK) || (n_phase == PH_FAIL);
    assign o_result.init_ok       = (n_phase == PH_OK);
    assign o_result.card_v2       = n_v2;
    assign o_result.card_hc       = n_csd_hc;
    assign o_result.card_rca      = n_rca;
    assign o_result.sector_count  = n_sectors;
    assign o_result.clock_divider = !(n_v2 && n_ocr_hc);

    `ASSERT_RST(a_start_goes_cmd0, i_adv && (i_step.func == FUNC_START) |=> (r_phase == PH_CMD0), "start request did not enter the reset phase")
    `ASSERT_ALWAYS(a_ok_implies_done, o_result.init_ok |-> o_result.init_done, "success flagged without sequence end")
    `ASSERT_RST(a_idle_no_issue, i_adv && (i_step.func == FUNC_DONE) && (r_phase == PH_IDLE) |-> !o_result.issue_cmd, "command issued from idle")

endmodule

### rtl/sd_card_init_sequencer.sv
// ----------------------------------------------------------------------------
// sd_card_init_sequencer
// path: a request is held in the input register, then enters the result register
// when it advances, which it does only while the result register is free or draining
// throughput: one request per cycle while the result channel keeps up, set by the
// single next-state pass between the input register and the result register
// reset: synchronous active low; phase idle, card facts cleared, config defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sd_card_init_sequencer
    import sdi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic                  i_timed_out,
    input  logic                  i_crc_failed,
    input  logic [31:0]           i_resp_word0,
    input  logic [31:0]           i_resp_word1,
    input  logic [31:0]           i_resp_word2,
    input  logic [31:0]           i_resp_word3,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_issue_cmd,
    output logic [5:0]            o_cmd_index,
    output logic [31:0]           o_cmd_arg,
    output logic [1:0]            o_resp_kind,
    output logic                  o_init_done,
    output logic                  o_init_ok,
    output logic                  o_card_v2,
    output logic                  o_card_hc,
    output logic [15:0]           o_card_rca,
    output logic [SECT_W-1:0]     o_sector_count,
    output logic                  o_clock_divider
);

`include "assert_macros.svh"

    // configuration registers
    logic [3:0]  r_reset_repeats;
    logic [15:0] r_ready_try_limit;

    // input register: one request waiting for the decision pass
    logic  r_in_valid;
    t_step r_in;

    // result register
    logic    r_out_valid;
    t_result r_out;

    logic      w_adv;
    t_csd_info w_csd;
    t_result   w_result;

    // the held request moves on whenever the result register is free
    // or is being emptied in the same cycle
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_repeats   <= RESET_REPEATS_DEF;
            r_ready_try_limit <= READY_TRY_LIMIT_DEF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RESET_REPEATS:   r_reset_repeats   <= i_cfg_data[3:0];
                CFG_READY_TRY_LIMIT: r_ready_try_limit <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // request capture; the fourth response word holds no field used here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.func       <= i_func;
            r_in.timed_out  <= i_timed_out;
            r_in.crc_failed <= i_crc_failed;
            r_in.resp_word0 <= i_resp_word0;
            r_in.resp_word1 <= i_resp_word1;
            r_in.resp_word2 <= i_resp_word2;
        end
    end

    // csd capacity decode of the held request
    sdi_csd_decode u_csd (
        .i_word0 (r_in.resp_word0),
        .i_word1 (r_in.resp_word1),
        .i_word2 (r_in.resp_word2),
        .o_csd   (w_csd)
    );

    // phase machine; its state commits only when the request advances
    sdi_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_adv             (w_adv),
        .i_step            (r_in),
        .i_reset_repeats   (r_reset_repeats),
        .i_ready_try_limit (r_ready_try_limit),
        .i_csd             (w_csd),
        .o_result          (w_result)
    );

    // result register: loads on advance, drains on downstream ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_issue_cmd     = r_out.issue_cmd;
    assign o_cmd_index     = r_out.cmd_index;
    assign o_cmd_arg       = r_out.cmd_arg;
    assign o_resp_kind     = r_out.resp_kind;
    assign o_init_done     = r_out.init_done;
    assign o_init_ok       = r_out.init_ok;
    assign o_card_v2       = r_out.card_v2;
    assign o_card_hc       = r_out.card_hc;
    assign o_card_rca      = r_out.card_rca;
    assign o_sector_count  = r_out.sector_count;
    assign o_clock_divider = r_out.clock_divider;

    `ASSERT_RST(a_adv_fills_result, w_adv |=> r_out_valid, "advanced request left no result")
    `ASSERT_RST(a_held_request_kept, r_in_valid && !w_adv |=> r_in_valid, "held request dropped without advancing")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd card init sequencer testbench
// drives bring-up runs of card events (start, command finished) into the
// sequencer, predicts each next command and the recorded card facts in a
// local state machine, and checks every result field by field
// ----------------------------------------------------------------------------

module testbench;
    import sdi_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int NUM_SETTINGS = 5;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_SPACING = 700;
    localparam int PHASE_EVENTS = 350;

    // one card event as the host controller reports it
    typedef struct packed {
        logic             func;
        logic             timed_out;
        logic             crc_failed;
        logic [3:0][31:0] words;
    } t_req;

    // bring-up position of the predicted sequencer
    typedef enum logic [3:0] {
        ST_IDLE, ST_CMD0, ST_CMD8, ST_CMD55, ST_ACMD41,
        ST_CMD2, ST_CMD3, ST_CMD9, ST_CMD7, ST_OK, ST_FAIL
    } t_seq_state;

    // where a random bring-up goes wrong, if anywhere
    typedef enum int {
        FLT_NONE, FLT_CMD0_TMO, FLT_CMD8_NOANS, FLT_CMD2,
        FLT_CMD3, FLT_CMD9, FLT_CMD7, FLT_ABORT
    } t_fault;

    // dut ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_func = 1'b0;
    logic                  i_timed_out = 1'b0;
    logic                  i_crc_failed = 1'b0;
    logic [31:0]           i_resp_word0 = '0;
    logic [31:0]           i_resp_word1 = '0;
    logic [31:0]           i_resp_word2 = '0;
    logic [31:0]           i_resp_word3 = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_issue_cmd;
    logic [5:0]            o_cmd_index;
    logic [31:0]           o_cmd_arg;
    logic [1:0]            o_resp_kind;
    logic                  o_init_done;
    logic                  o_init_ok;
    logic                  o_card_v2;
    logic                  o_card_hc;
    logic [15:0]           o_card_rca;
    logic [SECT_W-1:0]     o_sector_count;
    logic                  o_clock_divider;

    // stimulus and expectations
    t_req    card_events[$];
    t_result predicted_cmds[$];
    t_req    offered = '0;
    t_req    next_req;
    t_result observed;
    t_result wanted;
    int      events_queued = 0;
    int      reqs_accepted = 0;
    int      results_checked = 0;
    int      mismatches = 0;
    int      ok_runs = 0;
    int      fail_runs = 0;
    int      cycles = 0;
    int      tx_wait = 0;
    int      rx_wait = 0;
    int      hold_left = 0;
    int      next_hold_at = 200;
    logic    calm = 1'b0;

    // predicted sequencer state and its copy of the registers
    t_seq_state        seq_state = ST_IDLE;
    logic [15:0]       tries = '0;
    logic              card_v2 = 1'b0;
    logic              ocr_hc = 1'b0;
    logic              csd_hc = 1'b0;
    logic [15:0]       rca = '0;
    logic [SECT_W-1:0] sectors = '0;
    logic [3:0]        cmd0_repeats = RESET_REPEATS_DEF;
    logic [15:0]       acmd41_limit = READY_TRY_LIMIT_DEF;

    sd_card_init_sequencer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_timed_out     (i_timed_out),
        .i_crc_failed    (i_crc_failed),
        .i_resp_word0    (i_resp_word0),
        .i_resp_word1    (i_resp_word1),
        .i_resp_word2    (i_resp_word2),
        .i_resp_word3    (i_resp_word3),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_issue_cmd     (o_issue_cmd),
        .o_cmd_index     (o_cmd_index),
        .o_cmd_arg       (o_cmd_arg),
        .o_resp_kind     (o_resp_kind),
        .o_init_done     (o_init_done),
        .o_init_ok       (o_init_ok),
        .o_card_v2       (o_card_v2),
        .o_card_hc       (o_card_hc),
        .o_card_rca      (o_card_rca),
        .o_sector_count  (o_sector_count),
        .o_clock_divider (o_clock_divider)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // next command and card facts for one accepted request
    function automatic t_result sequencer_step(input t_req rq);
        t_result     res;
        logic        bad;
        logic [31:0] r0;
        logic [7:0]  csd [16];
        logic [3:0]  rbl;
        logic [11:0] v1_size;
        logic [2:0]  v1_mult;
        logic [21:0] v2_size;
        logic [63:0] total;
        int          sh;
        t_seq_state  was;
        res = '0;
        bad = rq.timed_out | rq.crc_failed;
        r0  = rq.words[0];
        was = seq_state;
        if (rq.func == FUNC_START) begin
            // a start restarts from cmd0 whatever the position
            card_v2 = 1'b0;
            ocr_hc  = 1'b0;
            csd_hc  = 1'b0;
            rca     = '0;
            sectors = '0;
            tries   = 16'd1;
            seq_state = ST_CMD0;
            {res.issue_cmd, res.cmd_index, res.cmd_arg, res.resp_kind} =
                {1'b1, CMD_GO_IDLE, 32'd0, RK_NONE};
        end else begin
            case (seq_state)
                ST_CMD0: begin
                    // only the flags of the last go-idle count
                    if (tries < 16'(cmd0_repeats)) begin
                        tries = tries + 16'd1;
                        {res.issue_cmd, res.cmd_index, res.cmd_arg, res.resp_kind} =
                            {1'b1, CMD_GO_IDLE, 32'd0, RK_NONE};
                    end else if (rq.timed_out) begin
                        seq_state = ST_FAIL;
                    end else begin
                        seq_state = ST_CMD8;
                        {res.issue_cmd, res.cmd_index, res.cmd_arg, res.resp_kind} =
                            {1'b1, CMD_SEND_IF, CMD8_ARG, RK_SHORT};
                    end
                end
                ST_CMD8: begin
                    // no answer or a wrong echo means a v1 card, not a failure
                    card_v2 = !bad && r0[7:0] == CMD8_ECHO && r0[14:9] == '0;
                    tries = '0;
                    seq_state = ST_CMD55;
                    {res.issue_cmd, res.cmd_index, res.cmd_arg, res.resp_kind} =
                        {1'b1, CMD_APP, 32'd0, RK_SHORT};
                end
                ST_CMD55: begin
                    seq_state = ST_ACMD41;
                    {res.issue_cmd, res.cmd_index, res.cmd_arg, res.resp_kind} =
                        {1'b1, CMD_SD_OP_COND,
                         OCR_ARG_BASE | (card_v2 ? OCR_HCS : 32'd0), RK_NOCRC};
                end
                ST_ACMD41: begin
                    tries = tries + 16'd1;
                    if ((!rq.timed_out && r0[31]) || tries >= acmd41_limit) begin
                        ocr_hc = card_v2 && r0[30];
                        seq_state = ST_CMD2;
                        {res.issue_cmd, res.cmd_index, res.cmd_arg, res.resp_kind} =
                            {1'b1, CMD_ALL_SEND_ID, 32'd0, RK_LONG};
                    end else begin
                        seq_state = ST_CMD55;
                        {res.issue_cmd, res.cmd_index, res.cmd_arg, res.resp_kind} =
                            {1'b1, CMD_APP, 32'd0, RK_SHORT};
                    end
                end
                ST_CMD2: begin
                    if (bad) begin
                        seq_state = ST_FAIL;
                    end else begin
                        seq_state = ST_CMD3;
                        {res.issue_cmd, res.cmd_index, res.cmd_arg, res.resp_kind} =
                            {1'b1, CMD_SEND_RCA, 32'd0, RK_SHORT};
                    end
                end
                ST_CMD3: begin
                    if (bad) begin
                        seq_state = ST_FAIL;
                    end else begin
                        rca = r0[31:16];
                        seq_state = ST_CMD9;
                        {res.issue_cmd, res.cmd_index, res.cmd_arg, res.resp_kind} =
                            {1'b1, CMD_SEND_CSD, {r0[31:16], 16'h0}, RK_LONG};
                    end
                end
                ST_CMD9: begin
                    if (bad) begin
                        seq_state = ST_FAIL;
                    end else begin
                        // csd byte 0 is the top byte of word 0
                        for (int n = 0; n < 16; n++)
                            csd[n] = 8'(rq.words[n / 4] >> (24 - 8 * (n % 4)));
                        if (csd[0][7:6] == 2'b00) begin
                            // v1 layout, short block length gives no extra shift
                            rbl     = csd[5][3:0];
                            v1_size = {csd[6][1:0], csd[7], csd[8][7:6]};
                            v1_mult = {csd[9][1:0], csd[10][7]};
                            sh      = v1_mult + 2 + ((rbl >= 9) ? rbl - 9 : 0);
                            total   = (64'(v1_size) + 64'd1) << sh;
                            csd_hc  = 1'b0;
                        end else begin
                            // any nonzero structure uses the v2 layout
                            v2_size = {csd[7][5:0], csd[8], csd[9]};
                            total   = (64'(v2_size) + 64'd1) * 64'd1024;
                            csd_hc  = 1'b1;
                        end
                        sectors = total[SECT_W-1:0];
                        seq_state = ST_CMD7;
                        {res.issue_cmd, res.cmd_index, res.cmd_arg, res.resp_kind} =
                            {1'b1, CMD_SELECT, {rca, 16'h0}, RK_SHORT};
                    end
                end
                ST_CMD7: seq_state = bad ? ST_FAIL : ST_OK;
                default: ;
            endcase
        end
        if (seq_state != was && seq_state == ST_OK)
            ok_runs++;
        if (seq_state != was && seq_state == ST_FAIL)
            fail_runs++;
        res.init_done     = seq_state == ST_OK || seq_state == ST_FAIL;
        res.init_ok       = seq_state == ST_OK;
        res.card_v2       = card_v2;
        res.card_hc       = csd_hc;
        res.card_rca      = rca;
        res.sector_count  = sectors;
        res.clock_divider = !(card_v2 && ocr_hc);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 40)
            $display("tb: result %0d %s got %0h expected %0h",
                     results_checked, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input t_result got, input t_result want);
        if (got.issue_cmd !== want.issue_cmd)
            report_mismatch("issue_cmd", 64'(got.issue_cmd), 64'(want.issue_cmd));
        if (got.cmd_index !== want.cmd_index)
            report_mismatch("cmd_index", 64'(got.cmd_index), 64'(want.cmd_index));
        if (got.cmd_arg !== want.cmd_arg)
            report_mismatch("cmd_arg", 64'(got.cmd_arg), 64'(want.cmd_arg));
        if (got.resp_kind !== want.resp_kind)
            report_mismatch("resp_kind", 64'(got.resp_kind), 64'(want.resp_kind));
        if (got.init_done !== want.init_done)
            report_mismatch("init_done", 64'(got.init_done), 64'(want.init_done));
        if (got.init_ok !== want.init_ok)
            report_mismatch("init_ok", 64'(got.init_ok), 64'(want.init_ok));
        if (got.card_v2 !== want.card_v2)
            report_mismatch("card_v2", 64'(got.card_v2), 64'(want.card_v2));
        if (got.card_hc !== want.card_hc)
            report_mismatch("card_hc", 64'(got.card_hc), 64'(want.card_hc));
        if (got.card_rca !== want.card_rca)
            report_mismatch("card_rca", 64'(got.card_rca), 64'(want.card_rca));
        if (got.sector_count !== want.sector_count)
            report_mismatch("sector_count", 64'(got.sector_count), 64'(want.sector_count));
        if (got.clock_divider !== want.clock_divider)
            report_mismatch("clock_divider", 64'(got.clock_divider),
                            64'(want.clock_divider));
    endtask

    // idle length between requests or results: mostly none, a few long
    function automatic int idle_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [3:0][31:0] rand_words();
        return {$urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    function automatic logic [3:0][31:0] words4(input logic [31:0] w0, input logic [31:0] w1,
                                                input logic [31:0] w2, input logic [31:0] w3);
        return {w3, w2, w1, w0};
    endfunction

    task automatic push_req(input logic func, input logic tmo, input logic crc,
                            input logic [3:0][31:0] w);
        card_events.push_back('{func, tmo, crc, w});
        events_queued++;
    endtask

    // command finished cleanly, or with a timeout and/or crc error
    task automatic push_completion(input logic fails, input logic [3:0][31:0] w);
        logic tmo;
        tmo = coin();
        if (fails)
            push_req(FUNC_DONE, tmo, !tmo || coin(), w);
        else
            push_req(FUNC_DONE, 1'b0, 1'b0, w);
    endtask

    // one well-formed bring-up with random content, sometimes broken off
    task automatic queue_bringup();
        t_fault           fault;
        int               reps;
        int               slow;
        logic             ready;
        logic             tmo;
        logic [3:0][31:0] w;
        fault = ($urandom_range(0, 2) == 0) ? t_fault'($urandom_range(1, 7)) : FLT_NONE;
        reps  = (cmd0_repeats == 0) ? 1 : int'(cmd0_repeats);
        slow  = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 3);
        push_req(FUNC_START, coin(), coin(), rand_words());
        for (int i = 1; i < reps; i++)
            push_req(FUNC_DONE, coin(), coin(), rand_words());
        push_req(FUNC_DONE, fault == FLT_CMD0_TMO, coin(), rand_words());
        if (fault == FLT_CMD0_TMO)
            return;
        // interface condition: mostly a proper echo
        w = rand_words();
        if ($urandom_range(0, 3) != 0) begin
            w[0][7:0] = CMD8_ECHO;
            if ($urandom_range(0, 3) != 0)
                w[0][14:9] = '0;
        end
        push_completion(fault == FLT_CMD8_NOANS, w);
        // app command / op cond pairs until ready or out of tries
        for (int n = 1; ; n++) begin
            push_req(FUNC_DONE, coin(), coin(), rand_words());
            ready = n > slow;
            tmo   = !ready && $urandom_range(0, 3) == 0;
            w     = rand_words();
            w[0][31] = ready || (tmo && coin());
            push_req(FUNC_DONE, tmo, coin(), w);
            if (ready || n >= acmd41_limit)
                break;
        end
        if (fault == FLT_ABORT)
            return;
        push_completion(fault == FLT_CMD2, rand_words());
        if (fault == FLT_CMD2)
            return;
        push_completion(fault == FLT_CMD3, rand_words());
        if (fault == FLT_CMD3)
            return;
        w = rand_words();
        if (coin())
            w[0][31:30] = 2'b00;
        push_completion(fault == FLT_CMD9, w);
        if (fault == FLT_CMD9)
            return;
        push_completion(fault == FLT_CMD7, rand_words());
    endtask

    task automatic fill_random(input int count);
        int goal;
        goal = events_queued + count;
        while (events_queued < goal) begin
            queue_bringup();
            // stray completion, ignored once the run has ended
            if ($urandom_range(0, 4) == 0)
                push_req(FUNC_DONE, coin(), coin(), rand_words());
        end
    endtask

    task automatic set_config(input logic [3:0] rep, input logic [15:0] lim);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_RESET_REPEATS;
        i_cfg_data  <= CFG_DATA_W'(rep);
        @(posedge i_clk);
        i_cfg_index <= CFG_READY_TRY_LIMIT;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cmd0_repeats = rep;
        acmd41_limit = lim;
    endtask

    // until every request is taken and every result has come back
    task automatic wait_idle(input int settle);
        while (card_events.size() != 0 || i_in_valid || predicted_cmds.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // request driver: predicts on acceptance, then offers the next request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_wait    <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                predicted_cmds.push_back(sequencer_step(offered));
                reqs_accepted <= reqs_accepted + 1;
            end
            if (tx_wait != 0) begin
                tx_wait    <= tx_wait - 1;
                i_in_valid <= 1'b0;
            end else if (card_events.size() != 0) begin
                next_req      = card_events.pop_front();
                offered      <= next_req;
                i_func       <= next_req.func;
                i_timed_out  <= next_req.timed_out;
                i_crc_failed <= next_req.crc_failed;
                i_resp_word0 <= next_req.words[0];
                i_resp_word1 <= next_req.words[1];
                i_resp_word2 <= next_req.words[2];
                i_resp_word3 <= next_req.words[3];
                i_in_valid   <= 1'b1;
                tx_wait      <= idle_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off every so often, so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (reqs_accepted >= next_hold_at) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + HOLD_SPACING;
        end
    end

    // result monitor: compares against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_wait     <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                observed = {o_issue_cmd, o_cmd_index, o_cmd_arg, o_resp_kind, o_init_done,
                            o_init_ok, o_card_v2, o_card_hc, o_card_rca, o_sector_count,
                            o_clock_divider};
                if (predicted_cmds.size() == 0) begin
                    report_mismatch("result with no request pending", 64'(observed), '0);
                end else begin
                    wanted = predicted_cmds.pop_front();
                    check_result(observed, wanted);
                end
                results_checked <= results_checked + 1;
            end
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait     <= rx_wait - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (o_out_valid && i_out_ready)
                    rx_wait <= idle_gap();
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int rep_set [NUM_SETTINGS];
        int lim_set [NUM_SETTINGS];
        rep_set = '{5, 1, 15, $urandom_range(2, 14), $urandom_range(1, 15)};
        lim_set = '{10000, 1, 65535, $urandom_range(2, 8), $urandom_range(1, 40)};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: a completion while idle is ignored
        push_req(FUNC_DONE, 1'b1, 1'b1, '1);
        // full v2 high-capacity bring-up under default registers
        push_req(FUNC_START, 1'b1, 1'b1, '1);
        push_req(FUNC_DONE, 1'b1, 1'b1, '0);
        repeat (3) push_req(FUNC_DONE, 1'b0, 1'b0, rand_words());
        // crc error on the last go-idle does not stop the run
        push_req(FUNC_DONE, 1'b0, 1'b1, rand_words());
        push_req(FUNC_DONE, 1'b0, 1'b0, words4(32'h0000_01AA, 0, 0, 0));
        // app command result is ignored
        push_req(FUNC_DONE, 1'b1, 1'b1, rand_words());
        // still busy, op cond crc ignored
        push_req(FUNC_DONE, 1'b0, 1'b1, words4(32'h4000_0000, '1, '1, '1));
        push_req(FUNC_DONE, 1'b0, 1'b0, '0);
        push_req(FUNC_DONE, 1'b0, 1'b1, words4(32'hC0FF_8000, 0, 0, 0));
        push_req(FUNC_DONE, 1'b0, 1'b0, '1);
        push_req(FUNC_DONE, 1'b0, 1'b0, words4(32'hFFFF_0000, 0, 0, 0));
        // largest v2 size: 2^32 sectors
        push_req(FUNC_DONE, 1'b0, 1'b0, words4(32'h4000_0000, 32'h0000_003F,
                                              32'hFFFF_0000, 0));
        push_req(FUNC_DONE, 1'b0, 1'b0, '0);
        // completion after the end is ignored
        push_req(FUNC_DONE, 1'b0, 1'b0, '0);
        // last go-idle timing out fails the run
        push_req(FUNC_START, 1'b0, 1'b0, '0);
        repeat (4) push_req(FUNC_DONE, 1'b0, 1'b1, rand_words());
        push_req(FUNC_DONE, 1'b1, 1'b0, rand_words());

        for (int k = 0; k < NUM_SETTINGS; k++) begin
            if (k != 0) begin
                wait_idle(4);
                set_config(4'(rep_set[k]), 16'(lim_set[k]));
            end
            // one setting runs with no random idle gaps, though hold-offs still apply
            calm = (k == 2);
            fill_random(PHASE_EVENTS);
        end

        wait_idle(20);
        $display("tb: %0d requests and %0d results checked over %0d register settings",
                 reqs_accepted, results_checked, NUM_SETTINGS);
        $display("tb: %0d bring-ups reached the ready state, %0d ended in error",
                 ok_runs, fail_runs);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
